[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RGBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rgbc_pkg.sv]
// ----------------------------------------------------------------------------
// rgbc_pkg
// types, constants and helpers of the rgbc nearest color classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbc_pkg;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned Q_W      = 17;
  localparam int unsigned DIV_NW   = 36;
  localparam int unsigned DIV_DW   = 17;
  localparam int unsigned DIV_BPS  = 4;
  localparam int unsigned DIV_LAT  = DIV_NW / DIV_BPS;
  localparam int unsigned DIST_W   = 48;
  localparam int unsigned NCOL     = 8;
  localparam int unsigned NEAR_LAT = 6;
  localparam int unsigned PIPE_LAT = 3 * DIV_LAT + 4 + NEAR_LAT;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [Q_W-1:0] DEG120  = 17'd30720;
  localparam logic [Q_W-1:0] DEG180  = 17'd46080;
  localparam logic [Q_W-1:0] DEG240  = 17'd61440;
  localparam logic [Q_W-1:0] DEG360  = 17'd92160;

  localparam logic [13:0] SV_SCALE = 14'd10000;

  typedef enum logic [2:0] {
    COL_BLACK,
    COL_WHITE,
    COL_RED,
    COL_GREEN,
    COL_BLUE,
    COL_YELLOW,
    COL_CYAN,
    COL_FUCHSIA
  } color_e;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } hue_sel_e;

  // reference hues, entry 0 at the low end
  localparam logic [NCOL-1:0][Q_W-1:0] TAB_H = {
    17'd76800, 17'd46080, 17'd15360, 17'd61440,
    17'd30720, 17'd0,     17'd0,     17'd0
  };
  localparam logic [NCOL-1:0] TAB_S_ONE = 8'b1111_1100;
  localparam logic [NCOL-1:0] TAB_V_ONE = 8'b1111_1110;

  typedef struct packed {
    logic [CNT_W-1:0] clear_count;
    logic [CNT_W-1:0] red_count;
    logic [CNT_W-1:0] green_count;
    logic [CNT_W-1:0] blue_count;
  } rgbc_in_t;

  typedef struct packed {
    color_e         color_code;
    logic [Q_W-1:0] hue_fixed;
    logic [Q_W-1:0] saturation_fixed;
    logic [Q_W-1:0] brightness_fixed;
  } rgbc_out_t;

  typedef struct packed {
    logic [Q_W-1:0] hue;
    logic [Q_W-1:0] sat;
    logic [Q_W-1:0] val;
    logic           clr_zero;
  } hsv_t;

  function automatic logic [Q_W-1:0] sat_q16(input logic [DIV_NW-1:0] q);
    return (q > DIV_NW'(ONE_Q16)) ? ONE_Q16 : q[Q_W-1:0];
  endfunction

endpackage

[rtl/core/rgbc_in_if.sv]
// ----------------------------------------------------------------------------
// rgbc_in_if
// valid/ready channel carrying one sensor reading per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbc_in_if import rgbc_pkg::*; ();
  logic     valid;
  logic     ready;
  rgbc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rgbc_out_if.sv]
// ----------------------------------------------------------------------------
// rgbc_out_if
// valid/ready channel carrying one classification result per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbc_out_if import rgbc_pkg::*; ();
  logic      valid;
  logic      ready;
  rgbc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rgbc_nearest_color_classifier_top.sv]
// ----------------------------------------------------------------------------
// rgbc_nearest_color_classifier_top
// rgbc reading to hsv and nearest named color, fully pipelined
//
//   channel   dir  handshake      word
//   in_ch     in   valid/ready    clear, red, green, blue counts
//   out_ch    out  valid/ready    color code, hue, saturation, brightness
//   cfg       in   cfg_wr_en_i    integration time code
//
// one word per cycle sustained while the output is not stalled
// the path runs through three 9-stage restoring dividers in turn, 4 quotient bits a stage
// reset clears the valid chain and loads integration time code 254
// a stalled output word freezes every stage, nothing is dropped or repeated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgbc_nearest_color_classifier_top import rgbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [7:0]         cfg_wr_data_i,
  rgbc_in_if.sink            in_ch,
  rgbc_out_if.source         out_ch
);

  typedef struct packed {
    logic [Q_W-1:0] mx;
    hue_sel_e       sel;
    logic           neg;
    logic           dz;
    logic           mxz;
    logic           cz;
  } hue_side_t;

  logic                en;
  logic [PIPE_LAT-1:0] v_q;
  logic [7:0]          code_q;
  logic [8:0]          div_w;

  logic [CNT_W-1:0]    cnt [4];
  logic [DIV_NW-1:0]   norm_quo [4];
  logic [Q_W-1:0]      nq_q [4];
  logic [DIV_NW-1:0]   ratio_quo [3];
  logic                cz_pipe_q [DIV_LAT];
  logic [Q_W-1:0]      rgb_q [3];
  logic                cz20_q;

  hue_side_t           side_d;
  hue_side_t           side_q [DIV_LAT+1];
  logic [Q_W-1:0]      delta_d, delta_q;
  logic [Q_W-1:0]      diff_d, diff_q;
  logic [DIV_NW-1:0]   sat_quo;
  logic [DIV_NW-1:0]   hue_quo;

  hsv_t                hsv_d, hsv_q;

  assign en          = !v_q[PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = v_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      code_q <= 8'd254;
    end else begin
      if (en) begin
        v_q <= {v_q[PIPE_LAT-2:0], in_ch.valid};
      end
      if (cfg_wr_en_i) begin
        code_q <= cfg_wr_data_i;
      end
    end
  end

  // normalize to full scale
  assign div_w  = 9'd256 - {1'b0, code_q};
  assign cnt[0] = in_ch.data.clear_count;
  assign cnt[1] = in_ch.data.red_count;
  assign cnt[2] = in_ch.data.green_count;
  assign cnt[3] = in_ch.data.blue_count;

  for (genvar k = 0; k < 4; k++) begin : g_norm
    rgbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (DIV_NW'({cnt[k], 6'b0})),
      .den_i (DIV_DW'(div_w)),
      .quo_o (norm_quo[k])
    );
  end

  // color over clear
  for (genvar k = 0; k < 3; k++) begin : g_ratio
    rgbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (DIV_NW'({nq_q[k+1], 16'b0})),
      .den_i (nq_q[0]),
      .quo_o (ratio_quo[k])
    );
  end

  // max, min and hue sector
  always_comb begin
    logic [Q_W-1:0] r_v, g_v, b_v, mx, mn, a_v, o_v;
    r_v = rgb_q[0];
    g_v = rgb_q[1];
    b_v = rgb_q[2];
    mx  = r_v;
    if (g_v > mx) begin
      mx = g_v;
    end
    if (b_v > mx) begin
      mx = b_v;
    end
    mn = r_v;
    if (g_v < mn) begin
      mn = g_v;
    end
    if (b_v < mn) begin
      mn = b_v;
    end
    if (mx == r_v) begin
      side_d.sel = SEL_RED;
      a_v = g_v;
      o_v = b_v;
    end else if (mx == g_v) begin
      side_d.sel = SEL_GREEN;
      a_v = b_v;
      o_v = r_v;
    end else begin
      side_d.sel = SEL_BLUE;
      a_v = r_v;
      o_v = g_v;
    end
    delta_d    = mx - mn;
    side_d.neg = a_v < o_v;
    diff_d     = (a_v < o_v) ? o_v - a_v : a_v - o_v;
    side_d.mx  = mx;
    side_d.dz  = (mx == mn);
    side_d.mxz = (mx == '0);
    side_d.cz  = cz20_q;
  end

  rgbc_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (DIV_NW'({delta_q, 16'b0})),
    .den_i (side_q[0].mx),
    .quo_o (sat_quo)
  );

  rgbc_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (DIV_NW'({diff_q, 14'b0}) - DIV_NW'({diff_q, 10'b0})),
    .den_i (delta_q),
    .quo_o (hue_quo)
  );

  // hue assembly with wrap
  always_comb begin
    logic [Q_W:0] base, hq, h;
    hq = {1'b0, hue_quo[Q_W-1:0]};
    case (side_q[DIV_LAT].sel)
      SEL_RED:   base = '0;
      SEL_GREEN: base = {1'b0, DEG120};
      SEL_BLUE:  base = {1'b0, DEG240};
      default:   base = '0;
    endcase
    if (!side_q[DIV_LAT].neg) begin
      h = base + hq;
    end else if (base >= hq) begin
      h = base - hq;
    end else begin
      h = base + {1'b0, DEG360} - hq;
    end
    if (h >= {1'b0, DEG360}) begin
      h = h - {1'b0, DEG360};
    end
    hsv_d.hue      = side_q[DIV_LAT].dz ? '0 : h[Q_W-1:0];
    hsv_d.sat      = side_q[DIV_LAT].mxz ? '0 : sat_quo[Q_W-1:0];
    hsv_d.val      = side_q[DIV_LAT].mx;
    hsv_d.clr_zero = side_q[DIV_LAT].cz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        nq_q[k] <= sat_q16(norm_quo[k]);
      end
      cz_pipe_q[0] <= (nq_q[0] == '0);
      for (int i = 1; i < DIV_LAT; i++) begin
        cz_pipe_q[i] <= cz_pipe_q[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        rgb_q[k] <= sat_q16(ratio_quo[k]);
      end
      cz20_q    <= cz_pipe_q[DIV_LAT-1];
      side_q[0] <= side_d;
      delta_q   <= delta_d;
      diff_q    <= diff_d;
      for (int i = 1; i <= DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
      hsv_q <= hsv_d;
    end
  end

  rgbc_nearest u_near (
    .clk_i (clk_i),
    .en_i  (en),
    .hsv_i (hsv_q),
    .res_o (out_ch.data)
  );

  `RGBC_ASSERT_NXT(a_accept_enters, in_ch.valid && en, v_q[0], "accepted word not in pipeline")
  `RGBC_ASSERT_NXT(a_stall_freezes, !en, $stable(v_q), "valid chain moved during stall")
  `RGBC_ASSERT_IMP(a_range, out_ch.valid,
    (out_ch.data.hue_fixed < DEG360) && (out_ch.data.saturation_fixed <= ONE_Q16)
    && (out_ch.data.brightness_fixed <= ONE_Q16), "result field out of range")
  `RGBC_ASSERT_IMP(a_grey_hue, out_ch.valid && (out_ch.data.saturation_fixed == '0),
    out_ch.data.hue_fixed == '0, "hue set on grey result")

endmodule

[rtl/core/rgbc_div.sv]
// ----------------------------------------------------------------------------
// rgbc_div
// pipelined restoring divider, 4 quotient bits per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_div import rgbc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_NW-1:0] quo_o
);

  logic [DIV_NW-1:0] num_q [DIV_LAT];
  logic [DIV_DW-1:0] rem_q [DIV_LAT];
  logic [DIV_DW-1:0] den_q [DIV_LAT];
  logic [DIV_NW-1:0] num_d [DIV_LAT];
  logic [DIV_DW-1:0] rem_d [DIV_LAT];
  logic [DIV_DW-1:0] den_d [DIV_LAT];

  always_comb begin
    logic [DIV_DW-1:0] r;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
    logic [DIV_DW:0]   t;
    for (int k = 0; k < DIV_LAT; k++) begin
      if (k == 0) begin
        r = '0;
        n = num_i;
        d = den_i;
      end else begin
        r = rem_q[k-1];
        n = num_q[k-1];
        d = den_q[k-1];
      end
      // quotient bits shift in as numerator bits shift out
      for (int j = 0; j < DIV_BPS; j++) begin
        t = {r, n[DIV_NW-1]};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          n = {n[DIV_NW-2:0], 1'b1};
        end else begin
          n = {n[DIV_NW-2:0], 1'b0};
        end
        r = t[DIV_DW-1:0];
      end
      rem_d[k] = r;
      num_d[k] = n;
      den_d[k] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        num_q[k] <= num_d[k];
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = num_q[DIV_LAT-1];

endmodule

[rtl/core/rgbc_nearest.sv]
// ----------------------------------------------------------------------------
// rgbc_nearest
// squared hsv distance to the eight reference colors and registered argmin tree
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbc_nearest import rgbc_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  hsv_t      hsv_i,
  output rgbc_out_t res_o
);

  hsv_t              hsv_q [NEAR_LAT-1];

  logic [31:0]       dhsq_d [NCOL];
  logic [31:0]       dhsq_q [NCOL];
  logic [33:0]       s_near_d, s_far_d, v_near_d, v_far_d;
  logic [33:0]       s_near_q, s_far_q, v_near_q, v_far_q;

  logic [DIST_W-1:0] hterm_q [NCOL];
  logic [DIST_W-1:0] st_near_q, st_far_q, vt_near_q, vt_far_q;

  logic [DIST_W-1:0] dist_q [NCOL];

  logic [DIST_W-1:0] l1_dist_q [4];
  color_e            l1_code_q [4];
  logic [DIST_W-1:0] l2_dist_q [2];
  color_e            l2_code_q [2];

  rgbc_out_t         res_d;

  // hue distance with wrap at half a turn
  always_comb begin
    logic [Q_W-1:0] d;
    logic [Q_W-1:0] s_far;
    logic [Q_W-1:0] v_far;
    for (int i = 0; i < NCOL; i++) begin
      d = (hsv_i.hue >= TAB_H[i]) ? hsv_i.hue - TAB_H[i] : TAB_H[i] - hsv_i.hue;
      if (d > DEG180) begin
        d = DEG360 - d;
      end
      dhsq_d[i] = d[15:0] * d[15:0];
    end
    s_far    = ONE_Q16 - hsv_i.sat;
    v_far    = ONE_Q16 - hsv_i.val;
    s_near_d = {17'b0, hsv_i.sat} * {17'b0, hsv_i.sat};
    s_far_d  = {17'b0, s_far} * {17'b0, s_far};
    v_near_d = {17'b0, hsv_i.val} * {17'b0, hsv_i.val};
    v_far_d  = {17'b0, v_far} * {17'b0, v_far};
  end

  always_comb begin
    logic [DIST_W-1:0] bd;
    color_e            bc;
    bd = l2_dist_q[0];
    bc = l2_code_q[0];
    if (l2_dist_q[1] < bd) begin
      bc = l2_code_q[1];
    end
    if (hsv_q[NEAR_LAT-2].clr_zero) begin
      res_d.color_code       = COL_BLACK;
      res_d.hue_fixed        = '0;
      res_d.saturation_fixed = '0;
      res_d.brightness_fixed = '0;
    end else begin
      res_d.color_code       = bc;
      res_d.hue_fixed        = hsv_q[NEAR_LAT-2].hue;
      res_d.saturation_fixed = hsv_q[NEAR_LAT-2].sat;
      res_d.brightness_fixed = hsv_q[NEAR_LAT-2].val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsv_q[0] <= hsv_i;
      for (int k = 1; k < NEAR_LAT - 1; k++) begin
        hsv_q[k] <= hsv_q[k-1];
      end

      // squares
      for (int i = 0; i < NCOL; i++) begin
        dhsq_q[i] <= dhsq_d[i];
      end
      s_near_q <= s_near_d;
      s_far_q  <= s_far_d;
      v_near_q <= v_near_d;
      v_far_q  <= v_far_d;

      // scaled terms
      for (int i = 0; i < NCOL; i++) begin
        hterm_q[i] <= {dhsq_q[i], 16'b0};
      end
      st_near_q <= s_near_q * SV_SCALE;
      st_far_q  <= s_far_q * SV_SCALE;
      vt_near_q <= v_near_q * SV_SCALE;
      vt_far_q  <= v_far_q * SV_SCALE;

      // per-color sums
      for (int i = 0; i < NCOL; i++) begin
        dist_q[i] <= hterm_q[i] + (TAB_S_ONE[i] ? st_far_q : st_near_q)
                   + (TAB_V_ONE[i] ? vt_far_q : vt_near_q);
      end

      // argmin tree, lower entry wins a tie
      for (int p = 0; p < 4; p++) begin
        if (dist_q[2*p+1] < dist_q[2*p]) begin
          l1_dist_q[p] <= dist_q[2*p+1];
          l1_code_q[p] <= color_e'(3'(2*p+1));
        end else begin
          l1_dist_q[p] <= dist_q[2*p];
          l1_code_q[p] <= color_e'(3'(2*p));
        end
      end
      for (int p = 0; p < 2; p++) begin
        if (l1_dist_q[2*p+1] < l1_dist_q[2*p]) begin
          l2_dist_q[p] <= l1_dist_q[2*p+1];
          l2_code_q[p] <= l1_code_q[2*p+1];
        end else begin
          l2_dist_q[p] <= l1_dist_q[2*p];
          l2_code_q[p] <= l1_code_q[2*p];
        end
      end

      res_o <= res_d;
    end
  end

endmodule
